// ----- rtl/core/dpcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcm_pkg
// Shared types, geometry constants and helpers for the pad coordinate mapper.
// ----------------------------------------------------------------------------
package dpcm_pkg;

  // Detector geometry
  localparam int NumLinks    = 14;
  localparam int NumColumns  = 24;
  localparam int NumDilogics = 10;
  localparam int NumChannels = 48;
  localparam int NumModules  = 7;
  localparam int NumCathodes = 6;
  localparam int CathX       = 80;
  localparam int CathY       = 48;
  localparam int MaxCx       = 79;
  localparam int MaxCy       = 47;

  typedef enum logic [2:0] {
    REQ_HW2PAD  = 3'd0,
    REQ_PAD2HW  = 3'd1,
    REQ_ABS2PAD = 3'd2,
    REQ_PAD2ABS = 3'd3,
    REQ_HW2ABS  = 3'd4,
    REQ_ABS2HW  = 3'd5
  } req_e;

  typedef logic [23:0] pad_id_t;

  typedef struct packed {
    logic [3:0] eq;
    logic [4:0] col;
    logic [3:0] dil;
    logic [5:0] chn;
  } hw_coord_t;

  typedef struct packed {
    logic [2:0] mod;
    logic [7:0] x;
    logic [7:0] y;
  } abs_coord_t;

  // Front-end channel within a row group <-> row, and back
  localparam logic [2:0] CHAN_TO_ROW [6] = '{3'd3, 3'd2, 3'd4, 3'd1, 3'd5, 3'd0};
  localparam logic [2:0] ROW_TO_CHAN [6] = '{3'd5, 3'd3, 3'd1, 3'd0, 3'd2, 3'd4};

  // v / 6 by reciprocal multiply; exact for every 6-bit v
  function automatic logic [3:0] div6(input logic [5:0] v);
    logic [11:0] p;
    p = 12'(v) * 12'd43;
    return p[11:8];
  endfunction

  // v % 6, always below 6
  function automatic logic [2:0] mod6(input logic [5:0] v);
    logic [5:0] r;
    r = 6'(v - 6'(div6(v)) * 6'd6);
    return r[2:0];
  endfunction

endpackage

// ----- rtl/core/dpcm_hw2pad.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcm_hw2pad
// Readout hardware coordinates to packed pad identifier, with range check.
// ----------------------------------------------------------------------------
module dpcm_hw2pad (
  input  dpcm_pkg::hw_coord_t hw,
  output logic                ok,
  output dpcm_pkg::pad_id_t   pad
);
  import dpcm_pkg::*;

  logic [3:0] q;
  logic [2:0] r;
  logic [3:0] pc;
  logic [7:0] px;
  logic [7:0] py_raw;
  logic [7:0] py;

  always_comb begin
    ok = (hw.eq < 4'(NumLinks)) && (hw.col < 5'(NumColumns)) &&
         (hw.dil < 4'(NumDilogics)) && (hw.chn < 6'(NumChannels));
    q      = div6(hw.chn);
    r      = mod6(hw.chn);
    pc     = {1'b0, hw.col[4:3], 1'b1};
    px     = 8'(MaxCx) - {1'b0, hw.dil, q[2:0]};
    py_raw = 8'(hw.col[2:0]) * 8'd6 + 8'(CHAN_TO_ROW[r]);
    py     = py_raw;
    // even links read the mirrored cathode
    if (!hw.eq[0]) begin
      pc = 4'd5 - pc;
      py = 8'(MaxCy) - py_raw;
    end
    pad = {1'b0, hw.eq[3:1], pc, px, py};
  end

endmodule

// ----- rtl/core/dpcm_abs2pad.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcm_abs2pad
// Module-absolute coordinates to packed pad identifier, with range check.
// ----------------------------------------------------------------------------
module dpcm_abs2pad (
  input  dpcm_pkg::abs_coord_t coord,
  output logic                 ok,
  output dpcm_pkg::pad_id_t    pad
);
  import dpcm_pkg::*;

  logic [1:0] yq;
  logic       xhi;
  logic [7:0] xm;
  logic [7:0] ym;
  logic [3:0] ph;

  always_comb begin
    ok = (coord.mod < 3'(NumModules)) && (coord.x < 8'(2 * CathX)) &&
         (coord.y < 8'(3 * CathY));
    if (coord.y < 8'(CathY)) begin
      yq = 2'd0;
    end else if (coord.y < 8'(2 * CathY)) begin
      yq = 2'd1;
    end else begin
      yq = 2'd2;
    end
    ym  = coord.y - 8'(yq) * 8'(CathY);
    xhi = (coord.x >= 8'(CathX));
    xm  = xhi ? coord.x - 8'(CathX) : coord.x;
    ph  = {1'b0, yq, xhi};
    pad = {1'b0, coord.mod, ph, xm, ym};
  end

endmodule

// ----- rtl/core/dpcm_pad2hw.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcm_pad2hw
// Packed pad identifier to readout hardware coordinates (pad already checked).
// ----------------------------------------------------------------------------
module dpcm_pad2hw (
  input  dpcm_pkg::pad_id_t   pad,
  output dpcm_pkg::hw_coord_t hw
);
  import dpcm_pkg::*;

  logic [3:0] ph;
  logic [7:0] px;
  logic [7:0] py;
  logic [3:0] q;
  logic [2:0] r;

  always_comb begin
    ph     = pad[19:16];
    px     = 8'(MaxCx) - pad[15:8];
    py     = pad[7:0];
    hw.eq  = {pad[22:20], 1'b1};
    // even cathodes sit on the even link, mirrored in y
    if (!pad[16]) begin
      hw.eq = {pad[22:20], 1'b0};
      py    = 8'(MaxCy) - pad[7:0];
      ph    = 4'd5 - pad[19:16];
    end
    q      = div6(py[5:0]);
    r      = mod6(py[5:0]);
    hw.dil = px[6:3];
    hw.col = {ph[2:1], q[2:0]};
    hw.chn = 6'(px[2:0]) * 6'd6 + 6'(ROW_TO_CHAN[r]);
  end

endmodule

// ----- rtl/core/dpcm_pad2abs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcm_pad2abs
// Packed pad identifier to module-absolute coordinates (pad already checked).
// ----------------------------------------------------------------------------
module dpcm_pad2abs (
  input  dpcm_pkg::pad_id_t    pad,
  output dpcm_pkg::abs_coord_t coord
);
  import dpcm_pkg::*;

  always_comb begin
    coord.mod = pad[22:20];
    coord.x   = pad[15:8] + (pad[16] ? 8'(CathX) : 8'd0);
    coord.y   = 8'(pad[19:17]) * 8'(CathY) + pad[7:0];
  end

endmodule

// ----- rtl/core/detector_pad_coordinate_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_pad_coordinate_mapper
// Converts pad positions between readout, packed pad id and module-absolute
// coordinates.
//
// Input channel (in_valid/in_ready) carries one request: req_type selects the
// conversion and the matching source fields are used. Output channel
// (out_valid/out_ready) returns one transaction per request, with unused
// fields zero and bad_coords set (all else zero) for out-of-range sources or
// an unknown req_type.
// Path: an accepted request goes into the input register, then its result into the
// result register that drives out_valid and the output fields. Throughput: one
// request per cycle while the receiver does not stall; the single conversion pass
// between the two registers sets this.
// Reset clears both valid flags; nothing is in flight afterwards.
// When the receiver stalls, the result register holds its transaction and the
// input register still takes one more; in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module detector_pad_coordinate_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [3:0]  equipment_in,
  input  logic [4:0]  column_in,
  input  logic [3:0]  dilogic_in,
  input  logic [5:0]  channel_in,
  input  logic [23:0] pad_in,
  input  logic [2:0]  mod_in,
  input  logic [7:0]  mod_x_in,
  input  logic [7:0]  mod_y_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] pad_out,
  output logic [3:0]  equipment_out,
  output logic [4:0]  column_out,
  output logic [3:0]  dilogic_out,
  output logic [5:0]  channel_out,
  output logic [2:0]  mod_out,
  output logic [7:0]  mod_x_out,
  output logic [7:0]  mod_y_out,
  output logic        bad_coords
);
  import dpcm_pkg::*;

  // input register
  logic       s1_valid;
  logic [2:0] s1_req;
  hw_coord_t  s1_hw;
  pad_id_t    s1_pad;
  abs_coord_t s1_abs;

  // result register
  pad_id_t    r_pad;
  hw_coord_t  r_hw;
  abs_coord_t r_abs;
  logic       r_bad;

  logic       s2_ready;
  logic       s1_fire;

  logic       h2p_ok;
  pad_id_t    h2p_pad;
  logic       a2p_ok;
  pad_id_t    a2p_pad;
  pad_id_t    p2h_src;
  pad_id_t    p2a_src;
  hw_coord_t  p2h_hw;
  abs_coord_t p2a_abs;
  logic       pin_ok;

  logic       ok;
  pad_id_t    pad_next;
  hw_coord_t  hw_next;
  abs_coord_t abs_next;

  assign s2_ready = !out_valid || out_ready;
  assign s1_fire  = s1_valid && s2_ready;
  assign in_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req <= req_type;
      s1_hw  <= '{eq: equipment_in, col: column_in, dil: dilogic_in, chn: channel_in};
      s1_pad <= pad_in;
      s1_abs <= '{mod: mod_in, x: mod_x_in, y: mod_y_in};
    end
  end

  dpcm_hw2pad u_hw2pad (
    .hw  (s1_hw),
    .ok  (h2p_ok),
    .pad (h2p_pad)
  );

  dpcm_abs2pad u_abs2pad (
    .coord (s1_abs),
    .ok    (a2p_ok),
    .pad   (a2p_pad)
  );

  // composed requests feed the intermediate pad id into the second leg
  assign p2h_src = (s1_req == REQ_ABS2HW) ? a2p_pad : s1_pad;
  assign p2a_src = (s1_req == REQ_HW2ABS) ? h2p_pad : s1_pad;

  dpcm_pad2hw u_pad2hw (
    .pad (p2h_src),
    .hw  (p2h_hw)
  );

  dpcm_pad2abs u_pad2abs (
    .pad   (p2a_src),
    .coord (p2a_abs)
  );

  assign pin_ok = (s1_pad[23:20] < 4'(NumModules)) && (s1_pad[19:16] < 4'(NumCathodes)) &&
                  (s1_pad[15:8] < 8'(CathX)) && (s1_pad[7:0] < 8'(CathY));

  always_comb begin
    ok       = 1'b0;
    pad_next = '0;
    hw_next  = '0;
    abs_next = '0;
    unique case (req_e'(s1_req))
      REQ_HW2PAD: begin
        ok       = h2p_ok;
        pad_next = h2p_pad;
      end
      REQ_PAD2HW: begin
        ok      = pin_ok;
        hw_next = p2h_hw;
      end
      REQ_ABS2PAD: begin
        ok       = a2p_ok;
        pad_next = a2p_pad;
      end
      REQ_PAD2ABS: begin
        ok       = pin_ok;
        abs_next = p2a_abs;
      end
      REQ_HW2ABS: begin
        ok       = h2p_ok;
        pad_next = h2p_pad;
        abs_next = p2a_abs;
      end
      REQ_ABS2HW: begin
        ok       = a2p_ok;
        pad_next = a2p_pad;
        hw_next  = p2h_hw;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!ok) begin
      pad_next = '0;
      hw_next  = '0;
      abs_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      r_pad <= pad_next;
      r_hw  <= hw_next;
      r_abs <= abs_next;
      r_bad <= !ok;
    end
  end

  assign pad_out       = r_pad;
  assign equipment_out = r_hw.eq;
  assign column_out    = r_hw.col;
  assign dilogic_out   = r_hw.dil;
  assign channel_out   = r_hw.chn;
  assign mod_out       = r_abs.mod;
  assign mod_x_out     = r_abs.x;
  assign mod_y_out     = r_abs.y;
  assign bad_coords    = r_bad;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the pad coordinate mapper transaction by transaction. A short table
// covers the field extremes, every conversion and the out-of-range and unknown
// request cases, and then a long random run follows with bursty input and a
// stalling receiver. Every result is compared field by field against the table
// entry or an in-bench model of the three coordinate systems.
// ----------------------------------------------------------------------------
module testbench;
  import dpcm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 950;
  localparam int SETTLE       = 8;

  // Unused request codes; both must come back flagged
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  // Channel within a six-channel group -> row, and row -> channel
  localparam logic [5:0][2:0] ROW_OF_CHAN = {3'd0, 3'd5, 3'd1, 3'd4, 3'd2, 3'd3};
  localparam logic [5:0][2:0] CHAN_OF_ROW = {3'd4, 3'd2, 3'd0, 3'd1, 3'd3, 3'd5};

  typedef struct packed {
    logic [2:0]  req;
    logic [3:0]  eq;
    logic [4:0]  col;
    logic [3:0]  dil;
    logic [5:0]  chn;
    pad_id_t     pad;
    logic [2:0]  md;
    logic [7:0]  x;
    logic [7:0]  y;
  } request_t;

  typedef struct packed {
    pad_id_t     pad;
    logic [3:0]  eq;
    logic [4:0]  col;
    logic [3:0]  dil;
    logic [5:0]  chn;
    logic [2:0]  md;
    logic [7:0]  mx;
    logic [7:0]  my;
    logic        bad;
  } mapping_t;

  typedef struct packed {
    request_t    rq;
    logic        known;
    mapping_t    res;
  } directed_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_BURSTY
  } stall_e;

  localparam mapping_t BAD_RESULT = mapping_t'(1);
  localparam mapping_t NO_RESULT  = mapping_t'(0);

  logic     clk        = 1'b0;
  logic     rst        = 1'b1;
  logic     in_valid   = 1'b0;
  logic     out_ready  = 1'b0;
  request_t stim       = '0;
  logic     row_known  = 1'b0;
  mapping_t row_result = '0;
  stall_e   stall_mode = STALL_NONE;

  logic        in_ready;
  logic        out_valid;
  logic [23:0] pad_out;
  logic [3:0]  equipment_out;
  logic [4:0]  column_out;
  logic [3:0]  dilogic_out;
  logic [5:0]  channel_out;
  logic [2:0]  mod_out;
  logic [7:0]  mod_x_out;
  logic [7:0]  mod_y_out;
  logic        bad_coords;

  mapping_t      pending_coords[$];
  directed_row_t directed_rows[$];
  int            mismatch_count = 0;
  int            results_seen   = 0;
  int            cycle_count    = 0;

  detector_pad_coordinate_mapper DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (stim.req),
    .equipment_in  (stim.eq),
    .column_in     (stim.col),
    .dilogic_in    (stim.dil),
    .channel_in    (stim.chn),
    .pad_in        (stim.pad),
    .mod_in        (stim.md),
    .mod_x_in      (stim.x),
    .mod_y_in      (stim.y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pad_out       (pad_out),
    .equipment_out (equipment_out),
    .column_out    (column_out),
    .dilogic_out   (dilogic_out),
    .channel_out   (channel_out),
    .mod_out       (mod_out),
    .mod_x_out     (mod_x_out),
    .mod_y_out     (mod_y_out),
    .bad_coords    (bad_coords)
  );

  always #2 clk = ~clk;

  // ---- coordinate model ----

  function automatic logic hw_to_pad_id(input request_t r, output pad_id_t id);
    int pc;
    int px;
    int py;
    id = '0;
    if (r.eq >= NumLinks || r.col >= NumColumns || r.dil >= NumDilogics ||
        r.chn >= NumChannels)
      return 1'b0;
    pc = (r.col / 8) * 2 + 1;
    px = MaxCx - (r.dil * 8 + r.chn / 6);
    py = (r.col % 8) * 6 + ROW_OF_CHAN[r.chn % 6];
    // even links see the even cathodes, mirrored in y
    if (!r.eq[0]) begin
      pc = 5 - pc;
      py = MaxCy - py;
    end
    id = {4'(r.eq >> 1), 4'(pc), 8'(px), 8'(py)};
    return 1'b1;
  endfunction

  function automatic logic abs_to_pad_id(input request_t r, output pad_id_t id);
    int ph;
    id = '0;
    if (r.md >= NumModules || r.x >= 2 * CathX || r.y >= 3 * CathY)
      return 1'b0;
    ph = (r.y / CathY) * 2 + ((r.x >= CathX) ? 1 : 0);
    id = {1'b0, r.md, 4'(ph), 8'(r.x % CathX), 8'(r.y % CathY)};
    return 1'b1;
  endfunction

  function automatic logic pad_is_valid(input pad_id_t id);
    return id[23:20] < NumModules && id[19:16] < NumCathodes &&
           id[15:8] < CathX && id[7:0] < CathY;
  endfunction

  function automatic void pad_to_readout(input pad_id_t id, inout mapping_t o);
    int ph;
    int px;
    int py;
    int eq;
    ph = id[19:16];
    px = MaxCx - id[15:8];
    py = id[7:0];
    eq = id[23:20] * 2 + 1;
    if (ph % 2 == 0) begin
      eq = eq - 1;
      py = MaxCy - py;
      ph = 5 - ph;
    end
    o.eq  = 4'(eq);
    o.dil = 4'(px / 8);
    o.col = 5'((ph / 2) * 8 + py / 6);
    o.chn = 6'((px % 8) * 6 + CHAN_OF_ROW[py % 6]);
  endfunction

  function automatic void pad_to_module(input pad_id_t id, inout mapping_t o);
    int ph;
    ph = id[19:16];
    o.md = id[22:20];
    o.mx = 8'(id[15:8] + ((ph % 2 != 0) ? CathX : 0));
    o.my = 8'((ph / 2) * CathY + id[7:0]);
  endfunction

  function automatic mapping_t map_coords(input request_t r);
    mapping_t o;
    pad_id_t  id;
    logic     ok;
    o  = '0;
    id = '0;
    ok = 1'b0;
    case (r.req)
      REQ_HW2PAD: begin
        ok = hw_to_pad_id(r, id);
        o.pad = id;
      end
      REQ_PAD2HW: begin
        ok = pad_is_valid(r.pad);
        if (ok) pad_to_readout(r.pad, o);
      end
      REQ_ABS2PAD: begin
        ok = abs_to_pad_id(r, id);
        o.pad = id;
      end
      REQ_PAD2ABS: begin
        ok = pad_is_valid(r.pad);
        if (ok) pad_to_module(r.pad, o);
      end
      REQ_HW2ABS: begin
        ok = hw_to_pad_id(r, id);
        o.pad = id;
        if (ok) pad_to_module(id, o);
      end
      REQ_ABS2HW: begin
        ok = abs_to_pad_id(r, id);
        o.pad = id;
        if (ok) pad_to_readout(id, o);
      end
      default: ok = 1'b0;
    endcase
    if (!ok) o = BAD_RESULT;
    return o;
  endfunction

  // ---- stimulus helpers ----

  function automatic request_t make_req(input logic [2:0] req, input int eq, input int col,
                                        input int dil, input int chn, input int pad,
                                        input int md, input int x, input int y);
    return {req, 4'(eq), 5'(col), 4'(dil), 6'(chn), 24'(pad), 3'(md), 8'(x), 8'(y)};
  endfunction

  function automatic mapping_t make_res(input int pad, input int eq, input int col,
                                        input int dil, input int chn, input int md,
                                        input int mx, input int my);
    return {24'(pad), 4'(eq), 5'(col), 4'(dil), 6'(chn), 3'(md), 8'(mx), 8'(my), 1'b0};
  endfunction

  function automatic void add_row(input request_t rq, input logic known, input mapping_t res);
    directed_row_t row;
    row.rq    = rq;
    row.known = known;
    row.res   = res;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Leans on the ends of the range
  function automatic int pick(input int lo, input int hi);
    case ($urandom_range(7, 0))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    if ($urandom_range(4, 0) != 0) begin
      r.req = 3'($urandom_range(5, 0));
      r.eq  = 4'(pick(0, NumLinks - 1));
      r.col = 5'(pick(0, NumColumns - 1));
      r.dil = 4'(pick(0, NumDilogics - 1));
      r.chn = 6'(pick(0, NumChannels - 1));
      r.pad = {4'(pick(0, NumModules - 1)), 4'(pick(0, NumCathodes - 1)),
               8'(pick(0, MaxCx)), 8'(pick(0, MaxCy))};
      r.md  = 3'(pick(0, NumModules - 1));
      r.x   = 8'(pick(0, 2 * CathX - 1));
      r.y   = 8'(pick(0, 3 * CathY - 1));
    end else begin
      // noise: anything the ports allow
      r.req = 3'($urandom);
      r.eq  = 4'($urandom);
      r.col = 5'($urandom);
      r.dil = 4'($urandom);
      r.chn = 6'($urandom);
      r.pad = 24'($urandom);
      r.md  = 3'($urandom);
      r.x   = 8'($urandom);
      r.y   = 8'($urandom);
    end
    return r;
  endfunction

  task automatic drive_request(input request_t rq, input logic known, input mapping_t res);
    stim       <= rq;
    row_known  <= known;
    row_result <= res;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off until every pending transaction has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_coords.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // ---- checking ----

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t result %0d: %s", $realtime, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : scoreboard
    mapping_t got;
    mapping_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        pending_coords.insert(pending_coords.size(),
                              row_known ? row_result : map_coords(stim));
      if (out_valid && out_ready) begin
        got = {pad_out, equipment_out, column_out, dilogic_out, channel_out,
               mod_out, mod_x_out, mod_y_out, bad_coords};
        if (pending_coords.size() == 0) begin
          flag_mismatch("transaction with nothing pending");
        end else begin
          want = pending_coords.pop_front();
          check_field("pad_out",       got.pad, want.pad);
          check_field("equipment_out", got.eq,  want.eq);
          check_field("column_out",    got.col, want.col);
          check_field("dilogic_out",   got.dil, want.dil);
          check_field("channel_out",   got.chn, want.chn);
          check_field("mod_out",       got.md,  want.md);
          check_field("mod_x_out",     got.mx,  want.mx);
          check_field("mod_y_out",     got.my,  want.my);
          check_field("bad_coords",    got.bad, want.bad);
        end
        results_seen++;
      end
    end
  end

  // Receiver drives out_ready by a stall habit that is redrawn at random
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) stall_mode <= stall_e'($urandom_range(3, 0));
    case (stall_mode)
      STALL_NONE:  out_ready <= 1'b1;
      STALL_LIGHT: out_ready <= ($urandom_range(3, 0) != 0);
      STALL_HALF:  out_ready <= 1'($urandom_range(1, 0));
      default:     out_ready <= ((cycle_count % 16) >= 10);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---- sequence ----

  initial begin
    int n;
    int burst;
    int gap;

    // hardware -> pad: both link parities, far corner, each field one past its end
    add_row(make_req(REQ_HW2PAD, 1, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            make_res(24'h014F03, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_req(REQ_HW2PAD, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            make_res(24'h044F2C, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_req(REQ_HW2PAD, 13, 23, 9, 47, 0, 0, 0, 0), 1'b1,
            make_res(24'h65002A, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_req(REQ_HW2PAD, 14, 0, 0, 0, 0, 0, 0, 0), 1'b1, BAD_RESULT);
    add_row(make_req(REQ_HW2PAD, 0, 24, 0, 0, 0, 0, 0, 0), 1'b1, BAD_RESULT);
    add_row(make_req(REQ_HW2PAD, 0, 0, 10, 0, 0, 0, 0, 0), 1'b1, BAD_RESULT);
    add_row(make_req(REQ_HW2PAD, 0, 0, 0, 48, 0, 0, 0, 0), 1'b1, BAD_RESULT);
    // pad -> hardware: inverse of the corners, each pad field one past its end
    add_row(make_req(REQ_PAD2HW, 0, 0, 0, 0, 24'h014F03, 0, 0, 0), 1'b1,
            make_res(0, 1, 0, 0, 0, 0, 0, 0));
    add_row(make_req(REQ_PAD2HW, 0, 0, 0, 0, 24'h65002A, 0, 0, 0), 1'b1,
            make_res(0, 13, 23, 9, 47, 0, 0, 0));
    add_row(make_req(REQ_PAD2HW, 0, 0, 0, 0, 24'h700000, 0, 0, 0), 1'b1, BAD_RESULT);
    add_row(make_req(REQ_PAD2HW, 0, 0, 0, 0, 24'h060000, 0, 0, 0), 1'b1, BAD_RESULT);
    add_row(make_req(REQ_PAD2HW, 0, 0, 0, 0, 24'h005000, 0, 0, 0), 1'b1, BAD_RESULT);
    add_row(make_req(REQ_PAD2HW, 0, 0, 0, 0, 24'h000030, 0, 0, 0), 1'b1, BAD_RESULT);
    // absolute -> pad
    add_row(make_req(REQ_ABS2PAD, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            make_res(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_req(REQ_ABS2PAD, 0, 0, 0, 0, 0, 6, 159, 143), 1'b1,
            make_res(24'h654F2F, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_req(REQ_ABS2PAD, 0, 0, 0, 0, 0, 7, 0, 0), 1'b1, BAD_RESULT);
    add_row(make_req(REQ_ABS2PAD, 0, 0, 0, 0, 0, 0, 160, 0), 1'b1, BAD_RESULT);
    add_row(make_req(REQ_ABS2PAD, 0, 0, 0, 0, 0, 0, 0, 144), 1'b1, BAD_RESULT);
    // pad -> absolute
    add_row(make_req(REQ_PAD2ABS, 0, 0, 0, 0, 24'h654F2F, 0, 0, 0), 1'b1,
            make_res(0, 0, 0, 0, 0, 6, 159, 143));
    add_row(make_req(REQ_PAD2ABS, 0, 0, 0, 0, 24'hFFFFFF, 0, 0, 0), 1'b1, BAD_RESULT);
    // composed conversions go to the model
    add_row(make_req(REQ_HW2ABS, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, NO_RESULT);
    add_row(make_req(REQ_HW2ABS, 13, 23, 9, 47, 0, 0, 0, 0), 1'b0, NO_RESULT);
    add_row(make_req(REQ_ABS2HW, 0, 0, 0, 0, 0, 6, 159, 143), 1'b0, NO_RESULT);
    // unknown requests with otherwise sane fields
    add_row(make_req(REQ_RSVD6, 1, 0, 0, 0, 24'h014F03, 0, 0, 0), 1'b1, BAD_RESULT);
    add_row(make_req(REQ_RSVD7, 1, 0, 0, 0, 24'h014F03, 0, 0, 0), 1'b1, BAD_RESULT);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      drive_request(directed_rows[i].rq, directed_rows[i].known, directed_rows[i].res);
    wait_for_results();

    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(40, 1);
      while (burst > 0 && n < RANDOM_ITEMS) begin
        drive_request(random_request(), 1'b0, NO_RESULT);
        n++;
        burst--;
        if (n == RANDOM_ITEMS / 2) wait_for_results();
      end
      gap = $urandom_range(8, 0);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/dpcm_pkg.sv
rtl/core/dpcm_hw2pad.sv
rtl/core/dpcm_abs2pad.sv
rtl/core/dpcm_pad2hw.sv
rtl/core/dpcm_pad2abs.sv
rtl/core/detector_pad_coordinate_mapper.sv
verif/testbench.sv
